FILE: src/gsb_pkg.sv
// Shared types, field widths and helpers for the genetic select-and-breed core.
package gsb_pkg;

  // Field widths of the stream items
  localparam int CHROMO_W       = 64;
  localparam int LEN_W          = 7;
  localparam int FIT_W          = 7;
  localparam int RAND_W         = 15;
  localparam int IN_DATA_W      = 112;
  localparam int IN_USER_W      = 2;
  localparam int OUT_DATA_W     = 144;

  // Item commands carried in s_tuser
  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_BREED = 1'b1;

  // Default and limits for the chromosome length
  localparam int CHROMO_BITS_DEF = 64;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
  localparam logic [LEN_W-1:0] LEN_MIN   = 7'd2;

  // Popcount slice per cycle and remainder bits retired per cycle
  localparam int CHUNK_W   = 16;
  localparam int DIV_STEPS = 4;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COUNT = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Which reduction the shared remainder unit is working on
  typedef enum logic [1:0] {
    OP_CUT,
    OP_POS_A,
    OP_POS_B
  } div_op_t;

  // Count the one bits of a popcount slice
  function automatic logic [4:0] ones16(input logic [CHUNK_W-1:0] v);
    logic [4:0] s;
    s = 5'd0;
    for (int i = 0; i < CHUNK_W; i++) begin
      s = s + {4'd0, v[i]};
    end
    return s;
  endfunction

endpackage

FILE: src/genetic_select_and_breed.sv
// Top level of the one-max genetic select-and-breed core.
//
//  channel | direction | handshake             | payload
//  s       | in        | s_tvalid / s_tready   | s_tdata, s_tuser: evaluate or breed item
//  m       | out       | m_tvalid / m_tready   | m_tdata: child, scores, best parent
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data: chromo_length
//
// Evaluate items sum the 16-bit popcount slices of the chromosome, one slice per
// cycle. Breed items use the shared remainder unit, which retires 4 quotient bits
// a cycle and runs three reductions (cut, first and second flip position).
// Reset is synchronous; it clears the parents, scores and sets chromo_length to 64.
// s_tready is high only while no item is in work; a stalled result holds in the
// output register and the next item may be accepted meanwhile.
module genetic_select_and_breed #(
  parameter int CHROMO_BITS = gsb_pkg::CHROMO_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata from bit 0: chromosome[63:0], rand_cut[14:0], rand_tie, rand_mut_count,
  // rand_mut_pos_a[14:0], rand_mut_pos_b[14:0], one zero bit
  input  logic [gsb_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser from bit 0: cmd, first_of_generation
  input  logic [gsb_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata from bit 0: child[63:0], best_score[6:0], second_score[6:0],
  // best_chromosome[63:0], target_reached, one zero bit
  output logic [gsb_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gsb_pkg::LEN_W-1:0]      cfg_data
);

  localparam int LEN_W      = gsb_pkg::LEN_W;
  localparam int FIT_W      = gsb_pkg::FIT_W;
  localparam int RAND_W     = gsb_pkg::RAND_W;
  localparam int CHROMO_W   = gsb_pkg::CHROMO_W;
  localparam int CHUNK_W    = gsb_pkg::CHUNK_W;
  localparam int CHUNKS     = (CHROMO_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W      = CHUNKS * CHUNK_W;
  localparam int CNT_W      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int DIV_CYCLES = (RAND_W + gsb_pkg::DIV_STEPS - 1) / gsb_pkg::DIV_STEPS;
  localparam int DVD_W      = DIV_CYCLES * gsb_pkg::DIV_STEPS;
  localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Input item fields
  logic              in_cmd;
  logic              in_first;
  logic [CHROMO_W-1:0] in_chromosome;
  logic [RAND_W-1:0] in_rand_cut;
  logic              in_rand_tie;
  logic              in_rand_mut_count;
  logic [RAND_W-1:0] in_rand_mut_pos_a;
  logic [RAND_W-1:0] in_rand_mut_pos_b;

  assign in_cmd            = s_tuser[0];
  assign in_first          = s_tuser[1];
  assign in_chromosome     = s_tdata[63:0];
  assign in_rand_cut       = s_tdata[78:64];
  assign in_rand_tie       = s_tdata[79];
  assign in_rand_mut_count = s_tdata[80];
  assign in_rand_mut_pos_a = s_tdata[95:81];
  assign in_rand_mut_pos_b = s_tdata[110:96];

  // Control and datapath registers
  gsb_pkg::state_t        state;
  gsb_pkg::div_op_t       op;
  logic [LEN_W-1:0]       chromo_length;
  logic                   cmd_r;
  logic                   first_r;
  logic                   tie_r;
  logic                   mut_r;
  logic [CHROMO_BITS-1:0] chrom_r;
  logic [RAND_W-1:0]      rand_a_r;
  logic [RAND_W-1:0]      rand_b_r;
  logic [PAD_W-1:0]       cnt_sh;
  logic [CNT_W-1:0]       chunk_cnt;
  logic [FIT_W-1:0]       score_acc;
  logic [STEP_W-1:0]      step_cnt;
  logic [DVD_W-1:0]       dvd;
  logic [LEN_W-1:0]       rem;
  logic [LEN_W-1:0]       cut_r;
  logic [LEN_W-1:0]       pos_a_r;
  logic [LEN_W-1:0]       pos_b_r;
  logic [FIT_W-1:0]       best_fit;
  logic [FIT_W-1:0]       second_fit;
  logic [CHROMO_BITS-1:0] best_parent;
  logic [CHROMO_BITS-1:0] second_parent;
  logic [gsb_pkg::OUT_DATA_W-1:0] out_data;

  logic accept;
  logic out_free;
  logic done_fire;

  assign s_tready  = (state == gsb_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign done_fire = (state == gsb_pkg::S_DONE) && out_free;
  assign m_tdata   = out_data;

  // Clamp the configured length to the supported range
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] quarter;

  always_comb begin
    if (chromo_length > LEN_W'(CHROMO_BITS)) begin
      len_eff = LEN_W'(CHROMO_BITS);
    end else if (chromo_length < gsb_pkg::LEN_MIN) begin
      len_eff = gsb_pkg::LEN_MIN;
    end else begin
      len_eff = chromo_length;
    end
  end

  assign quarter = len_eff >> 2;

  // Build the in-use bit mask
  logic [CHROMO_BITS-1:0] lmask;

  always_comb begin
    for (int i = 0; i < CHROMO_BITS; i++) begin
      lmask[i] = (LEN_W'(i) < len_eff);
    end
  end

  logic [CHROMO_BITS-1:0] in_chrom_masked;
  assign in_chrom_masked = in_chromosome[CHROMO_BITS-1:0] & lmask;

  // Shared remainder unit: retire several dividend bits per cycle
  logic [LEN_W-1:0] divisor;
  logic [LEN_W-1:0] rem_next;
  logic [DVD_W-1:0] dvd_next;

  always_comb begin
    logic [LEN_W:0]   r;
    logic [DVD_W-1:0] d;
    divisor = (op == gsb_pkg::OP_CUT) ? (len_eff >> 1) : len_eff;
    r = {1'b0, rem};
    d = dvd;
    for (int k = 0; k < gsb_pkg::DIV_STEPS; k++) begin
      r = {r[LEN_W-1:0], d[DVD_W-1]};
      d = d << 1;
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
      end
    end
    rem_next = r[LEN_W-1:0];
    dvd_next = d;
  end

  // Assemble the child from the parents and flip the chosen bits
  logic [CHROMO_BITS-1:0] below;
  logic [CHROMO_BITS-1:0] flips;
  logic [CHROMO_BITS-1:0] lo_src;
  logic [CHROMO_BITS-1:0] hi_src;
  logic [CHROMO_BITS-1:0] child_w;

  always_comb begin
    for (int i = 0; i < CHROMO_BITS; i++) begin
      below[i] = (LEN_W'(i) < cut_r);
      flips[i] = (LEN_W'(i) == pos_a_r) || (mut_r && (LEN_W'(i) == pos_b_r));
    end
    lo_src  = tie_r ? best_parent : second_parent;
    hi_src  = tie_r ? second_parent : best_parent;
    child_w = ((((lo_src & below) | (hi_src & ~below)) & lmask) ^ flips) & lmask;
  end

  // Select the parents after an evaluate item; also form the target flag and child
  logic [FIT_W-1:0]       best_fit_next;
  logic [FIT_W-1:0]       second_fit_next;
  logic [CHROMO_BITS-1:0] best_parent_next;
  logic [CHROMO_BITS-1:0] second_parent_next;
  logic                   target_next;
  logic [CHROMO_W-1:0]    child_out;

  always_comb begin
    best_fit_next      = best_fit;
    second_fit_next    = second_fit;
    best_parent_next   = best_parent;
    second_parent_next = second_parent;
    if (cmd_r == gsb_pkg::CMD_EVAL) begin
      if (first_r) begin
        best_fit_next      = score_acc;
        second_fit_next    = score_acc;
        best_parent_next   = chrom_r;
        second_parent_next = chrom_r;
      end else if (score_acc > best_fit) begin
        second_fit_next    = best_fit;
        second_parent_next = best_parent;
        best_fit_next      = score_acc;
        best_parent_next   = chrom_r;
      end else if (score_acc > second_fit) begin
        second_fit_next    = score_acc;
        second_parent_next = chrom_r;
      end
    end
    target_next = (second_fit_next == len_eff);
    child_out   = (cmd_r == gsb_pkg::CMD_BREED) ? CHROMO_W'(child_w) : '0;
  end

  // Sequencer and kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gsb_pkg::S_IDLE;
      op            <= gsb_pkg::OP_CUT;
      chromo_length <= gsb_pkg::LEN_RESET;
      m_tvalid      <= 1'b0;
      best_fit      <= '0;
      second_fit    <= '0;
      best_parent   <= '0;
      second_parent <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        chromo_length <= cfg_data;
      end

      case (state)
        gsb_pkg::S_IDLE: begin
          if (accept) begin
            state <= (in_cmd == gsb_pkg::CMD_BREED) ? gsb_pkg::S_DIV : gsb_pkg::S_COUNT;
            op    <= gsb_pkg::OP_CUT;
          end
        end
        gsb_pkg::S_COUNT: begin
          if (chunk_cnt == CNT_W'(CHUNKS - 1)) begin
            state <= gsb_pkg::S_DONE;
          end
        end
        gsb_pkg::S_DIV: begin
          if (step_cnt == STEP_W'(DIV_CYCLES - 1)) begin
            case (op)
              gsb_pkg::OP_CUT:   op <= gsb_pkg::OP_POS_A;
              gsb_pkg::OP_POS_A: op <= gsb_pkg::OP_POS_B;
              gsb_pkg::OP_POS_B: state <= gsb_pkg::S_DONE;
              default:           op <= gsb_pkg::OP_CUT;
            endcase
          end
        end
        gsb_pkg::S_DONE: begin
          if (out_free) begin
            state <= gsb_pkg::S_IDLE;
          end
        end
        default: state <= gsb_pkg::S_IDLE;
      endcase

      // Commit the parents and raise the result
      if (done_fire) begin
        m_tvalid      <= 1'b1;
        best_fit      <= best_fit_next;
        second_fit    <= second_fit_next;
        best_parent   <= best_parent_next;
        second_parent <= second_parent_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_cmd;
      first_r   <= in_first;
      tie_r     <= in_rand_tie;
      mut_r     <= in_rand_mut_count;
      chrom_r   <= in_chrom_masked;
      rand_a_r  <= in_rand_mut_pos_a;
      rand_b_r  <= in_rand_mut_pos_b;
      cnt_sh    <= PAD_W'(in_chrom_masked);
      chunk_cnt <= '0;
      score_acc <= '0;
      step_cnt  <= '0;
      rem       <= '0;
      dvd       <= DVD_W'(in_rand_cut);
    end

    // Sum one popcount slice
    if (state == gsb_pkg::S_COUNT) begin
      score_acc <= score_acc + FIT_W'(gsb_pkg::ones16(cnt_sh[CHUNK_W-1:0]));
      cnt_sh    <= cnt_sh >> CHUNK_W;
      chunk_cnt <= chunk_cnt + 1'b1;
    end

    // Advance the remainder unit; load the next dividend at the end of the cut and first position ops
    if (state == gsb_pkg::S_DIV) begin
      if (step_cnt == STEP_W'(DIV_CYCLES - 1)) begin
        step_cnt <= '0;
        rem      <= '0;
        case (op)
          gsb_pkg::OP_CUT: begin
            cut_r <= rem_next + quarter;
            dvd   <= DVD_W'(rand_a_r);
          end
          gsb_pkg::OP_POS_A: begin
            pos_a_r <= rem_next;
            dvd     <= DVD_W'(rand_b_r);
          end
          gsb_pkg::OP_POS_B: begin
            pos_b_r <= rem_next;
          end
          default: begin
            dvd <= dvd_next;
          end
        endcase
      end else begin
        step_cnt <= step_cnt + 1'b1;
        rem      <= rem_next;
        dvd      <= dvd_next;
      end
    end

    // Capture the result item
    if (done_fire) begin
      out_data <= {1'b0, target_next, CHROMO_W'(best_parent_next), second_fit_next,
                   best_fit_next, child_out};
    end
  end

  // Checks on the sequencer and datapath
  a_fit_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[70:64] >= m_tdata[77:71]))
    else $error("best score below second score");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in work");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == gsb_pkg::S_DIV) |-> (rem < divisor))
    else $error("partial remainder not below divisor");

  a_done: assert property (@(posedge clk) disable iff (rst)
    done_fire |=> (m_tvalid && (state == gsb_pkg::S_IDLE)))
    else $error("finished item not presented");

endmodule
